// ===== hw/rtl/vlw_pkg.sv =====
// ============================================================================
// vlw_pkg - shared types and constants of the voxel line walker
// Widths, axis and register codes, crossing-time bundle, depth clamp.
// ============================================================================
package vlw_pkg;

    localparam int VLW_GRID_SIZE  = 16;   // reset value of the grid size registers
    localparam int VLW_CFG_W      = 5;    // grid size register width
    localparam int VLW_CFG_IDX_W  = 2;    // register index width
    localparam int VLW_COORD_W    = 4;    // voxel coordinate width
    localparam int VLW_INDEX_W    = 12;   // linear index width
    localparam int VLW_TIME_W     = 12;   // crossing time width, holds 15*15*15
    localparam int VLW_STRIDE_W   = 8;    // per-axis time increment, holds 15*15
    localparam int VLW_PLANE_W    = 10;   // width times height, holds 31*31
    localparam int VLW_MUL_A_W    = 10;
    localparam int VLW_MUL_B_W    = 5;
    localparam int VLW_MUL_P_W    = VLW_MUL_A_W + VLW_MUL_B_W;
    localparam int VLW_WALK_LIMIT = 47;
    localparam int VLW_CNT_W      = 6;

    typedef enum logic [1:0] {
        AXIS_X = 2'd0,
        AXIS_Y = 2'd1,
        AXIS_Z = 2'd2
    } t_axis;

    typedef enum logic [VLW_CFG_IDX_W-1:0] {
        CFG_GRID_X = 2'd0,
        CFG_GRID_Y = 2'd1,
        CFG_GRID_Z = 2'd2
    } t_cfg_reg;

    // Crossing times and retirement flags of the three axes.
    typedef struct packed {
        logic                  late_x;
        logic                  late_y;
        logic                  late_z;
        logic [VLW_TIME_W-1:0] t_x;
        logic [VLW_TIME_W-1:0] t_y;
        logic [VLW_TIME_W-1:0] t_z;
    } t_race;

    // Clamp z below the grid depth; a zero depth clamps to 0.
    function automatic logic [VLW_COORD_W-1:0] clamp_z(
        input logic [VLW_COORD_W-1:0] z,
        input logic [VLW_CFG_W-1:0]   depth
    );
        logic [VLW_CFG_W-1:0] top;
        top = depth - 1'b1;
        if (depth == '0) begin
            clamp_z = '0;
        end else if ({1'b0, z} >= depth) begin
            clamp_z = top[VLW_COORD_W-1:0];
        end else begin
            clamp_z = z;
        end
    endfunction

endpackage

// ===== hw/rtl/vlw_axis_pick.sv =====
// ============================================================================
// vlw_axis_pick - next-axis choice of the walk
// Earliest crossing wins; ties go to z over y and to y over x; a retired axis never wins.
// ============================================================================
module vlw_axis_pick
    import vlw_pkg::*;
(
    input  t_race i_race,
    output t_axis o_axis
);

    logic x_before_y;
    logic x_before_z;
    logic y_before_z;

    assign x_before_y = !i_race.late_x && (i_race.late_y || (i_race.t_x < i_race.t_y));
    assign x_before_z = !i_race.late_x && (i_race.late_z || (i_race.t_x < i_race.t_z));
    assign y_before_z = !i_race.late_y && (i_race.late_z || (i_race.t_y < i_race.t_z));

    always_comb begin
        if (x_before_y && x_before_z) begin
            o_axis = AXIS_X;
        end else if (y_before_z) begin
            o_axis = AXIS_Y;
        end else begin
            o_axis = AXIS_Z;
        end
    end

endmodule

// ===== hw/rtl/voxel_line_walker_3d_unit.sv =====
// ============================================================================
// voxel_line_walker_3d_unit - 3D DDA voxel traversal between two voxels
// Walks from a start voxel to an end voxel one axis step per cycle and
// emits each voxel reached with its linear grid index and an end flag.
// ============================================================================
//
// Channel   Direction  Handshake                       Payload
// --------  ---------  ------------------------------  ---------------------------
// segment   in         start & !busy                   i_start_{x,y,z}, i_end_{x,y,z}
// voxel     out        o_result_strobe (one cycle)     o_voxel_{x,y,z}, o_voxel_index,
//                                                       o_last_step
// config    in         i_cfg_we                        i_cfg_idx, i_cfg_data
//
// Sequence: after the start transfer the block runs its setup states on the
// shared multiplier (three axis strides, plane stride, row and depth terms of
// the start index), then emits one voxel per cycle until it reaches the end
// voxel or the walk limit. A zero-length segment emits nothing and
// leaves busy low.
// Reset: synchronous, active low; grid sizes return to P_GRID_SIZE, the
// sequencer to idle and the strobe low.
// Stalls: none; each result transfers in the cycle its strobe is high.
// ============================================================================
module voxel_line_walker_3d_unit
    import vlw_pkg::*;
#(
    parameter int P_GRID_SIZE = VLW_GRID_SIZE
)
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    // configuration
    input  logic                     i_cfg_we,
    input  logic [VLW_CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [VLW_CFG_W-1:0]     i_cfg_data,
    // segment command
    input  logic                     start,
    output logic                     busy,
    input  logic [VLW_COORD_W-1:0]   i_start_x,
    input  logic [VLW_COORD_W-1:0]   i_start_y,
    input  logic [VLW_COORD_W-1:0]   i_start_z,
    input  logic [VLW_COORD_W-1:0]   i_end_x,
    input  logic [VLW_COORD_W-1:0]   i_end_y,
    input  logic [VLW_COORD_W-1:0]   i_end_z,
    // voxel results
    output logic                     o_result_strobe,
    output logic [VLW_COORD_W-1:0]   o_voxel_x,
    output logic [VLW_COORD_W-1:0]   o_voxel_y,
    output logic [VLW_COORD_W-1:0]   o_voxel_z,
    output logic [VLW_INDEX_W-1:0]   o_voxel_index,
    output logic                     o_last_step
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_STRIDE_X,
        S_STRIDE_Y,
        S_STRIDE_Z,
        S_PLANE,
        S_ROW,
        S_DEPTH,
        S_WALK
    } t_state;

    localparam logic [VLW_CFG_W-1:0] RST_SIZE = VLW_CFG_W'(P_GRID_SIZE);

    // ------------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------------
    t_state                   r_state, n_state;
    logic [VLW_CFG_W-1:0]     r_size_x, r_size_y, r_size_z;
    logic [VLW_COORD_W-1:0]   r_pos    [3];
    logic [VLW_COORD_W-1:0]   n_pos    [3];
    logic [VLW_COORD_W-1:0]   r_fin    [3];
    logic [VLW_COORD_W-1:0]   n_fin    [3];
    logic [VLW_COORD_W-1:0]   r_mag    [3];
    logic [VLW_COORD_W-1:0]   n_mag    [3];
    logic [2:0]               r_neg, n_neg;    // axis walks downwards
    logic [2:0]               r_zero, n_zero;  // axis has no delta
    logic [2:0]               r_late, n_late;  // axis retired after its idle step
    logic [VLW_TIME_W-1:0]    r_t      [3];
    logic [VLW_TIME_W-1:0]    n_t      [3];
    logic [VLW_STRIDE_W-1:0]  r_stride [3];
    logic [VLW_STRIDE_W-1:0]  n_stride [3];
    logic [VLW_PLANE_W-1:0]   r_plane, n_plane;
    logic [VLW_INDEX_W-1:0]   r_idx, n_idx;
    logic [VLW_CNT_W-1:0]     r_cnt, n_cnt;
    logic                     r_strobe, n_strobe;
    logic [VLW_COORD_W-1:0]   r_out_x, n_out_x;
    logic [VLW_COORD_W-1:0]   r_out_y, n_out_y;
    logic [VLW_COORD_W-1:0]   r_out_z, n_out_z;
    logic [VLW_INDEX_W-1:0]   r_out_idx, n_out_idx;
    logic                     r_out_last, n_out_last;

    // ------------------------------------------------------------------------
    // Combinational helpers
    // ------------------------------------------------------------------------
    logic [VLW_COORD_W-1:0]   in_start [3];
    logic [VLW_COORD_W-1:0]   in_end   [3];
    logic [VLW_COORD_W-1:0]   mag_one  [3];   // magnitude, zero taken as one
    logic [VLW_MUL_A_W-1:0]   mul_a;
    logic [VLW_MUL_B_W-1:0]   mul_b;
    logic [VLW_MUL_P_W-1:0]   mul_p;
    logic                     accept;
    logic                     same_voxel;
    t_race                    race;
    t_axis                    pick;
    logic [1:0]               ax;
    logic [VLW_INDEX_W-1:0]   idx_inc;
    logic [VLW_COORD_W-1:0]   step_pos [3];
    logic                     arrive;
    logic [VLW_CNT_W-1:0]     cnt_inc;

    assign in_start[0] = i_start_x;
    assign in_start[1] = i_start_y;
    assign in_start[2] = i_start_z;
    assign in_end[0]   = i_end_x;
    assign in_end[1]   = i_end_y;
    assign in_end[2]   = i_end_z;

    assign accept     = start && (r_state == S_IDLE);
    assign same_voxel = (i_start_x == i_end_x) && (i_start_y == i_end_y)
                        && (i_start_z == i_end_z);

    always_comb begin
        for (int a = 0; a < 3; a++) begin
            mag_one[a] = r_zero[a] ? VLW_COORD_W'(1) : r_mag[a];
        end
    end

    // Shared multiplier: one product per setup cycle.
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (r_state)
            S_STRIDE_X: begin
                mul_a = VLW_MUL_A_W'(mag_one[1]);
                mul_b = VLW_MUL_B_W'(mag_one[2]);
            end
            S_STRIDE_Y: begin
                mul_a = VLW_MUL_A_W'(mag_one[0]);
                mul_b = VLW_MUL_B_W'(mag_one[2]);
            end
            S_STRIDE_Z: begin
                mul_a = VLW_MUL_A_W'(mag_one[0]);
                mul_b = VLW_MUL_B_W'(mag_one[1]);
            end
            S_PLANE: begin
                mul_a = VLW_MUL_A_W'(r_size_x);
                mul_b = r_size_y;
            end
            S_ROW: begin
                mul_a = VLW_MUL_A_W'(r_size_x);
                mul_b = VLW_MUL_B_W'(r_pos[2'(AXIS_Y)]);
            end
            S_DEPTH: begin
                mul_a = r_plane;
                mul_b = VLW_MUL_B_W'(clamp_z(r_pos[2'(AXIS_Z)], r_size_z));
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p = VLW_MUL_P_W'(mul_a) * VLW_MUL_P_W'(mul_b);

    // Axis choice for the current walk step.
    assign race.late_x = r_late[0];
    assign race.late_y = r_late[1];
    assign race.late_z = r_late[2];
    assign race.t_x    = r_t[0];
    assign race.t_y    = r_t[1];
    assign race.t_z    = r_t[2];

    vlw_axis_pick u_axis_pick (
        .i_race (race),
        .o_axis (pick)
    );

    assign ax = pick;

    // Voxel after this step; an idle step on a zero-delta axis repeats it.
    always_comb begin
        for (int a = 0; a < 3; a++) begin
            if ((2'(a) == ax) && !r_zero[a]) begin
                step_pos[a] = r_neg[a] ? r_pos[a] - 1'b1 : r_pos[a] + 1'b1;
            end else begin
                step_pos[a] = r_pos[a];
            end
        end
    end

    // Index moves by one, a row, or a plane when the clamped depth changes.
    always_comb begin
        idx_inc = '0;
        case (pick)
            AXIS_X: idx_inc = r_zero[0] ? '0 : VLW_INDEX_W'(1);
            AXIS_Y: idx_inc = r_zero[1] ? '0 : VLW_INDEX_W'(r_size_x);
            AXIS_Z: begin
                if (clamp_z(step_pos[2], r_size_z) != clamp_z(r_pos[2], r_size_z)) begin
                    idx_inc = VLW_INDEX_W'(r_plane);
                end else begin
                    idx_inc = '0;
                end
            end
            default: idx_inc = '0;
        endcase
    end

    assign arrive  = (step_pos[0] == r_fin[0]) && (step_pos[1] == r_fin[1])
                     && (step_pos[2] == r_fin[2]);
    assign cnt_inc = r_cnt + 1'b1;

    // ------------------------------------------------------------------------
    // Sequencer next state
    // ------------------------------------------------------------------------
    always_comb begin
        n_state    = r_state;
        n_pos      = r_pos;
        n_fin      = r_fin;
        n_mag      = r_mag;
        n_neg      = r_neg;
        n_zero     = r_zero;
        n_late     = r_late;
        n_t        = r_t;
        n_stride   = r_stride;
        n_plane    = r_plane;
        n_idx      = r_idx;
        n_cnt      = r_cnt;
        n_strobe   = 1'b0;
        n_out_x    = r_out_x;
        n_out_y    = r_out_y;
        n_out_z    = r_out_z;
        n_out_idx  = r_out_idx;
        n_out_last = r_out_last;

        case (r_state)
            S_IDLE: begin
                if (start && !same_voxel) begin
                    for (int a = 0; a < 3; a++) begin
                        n_pos[a]  = in_start[a];
                        n_fin[a]  = in_end[a];
                        n_neg[a]  = in_end[a] < in_start[a];
                        n_zero[a] = in_end[a] == in_start[a];
                        n_mag[a]  = (in_end[a] < in_start[a]) ? in_start[a] - in_end[a]
                                                              : in_end[a] - in_start[a];
                        n_t[a]    = '0;
                    end
                    n_late  = '0;
                    n_cnt   = '0;
                    n_state = S_STRIDE_X;
                end
            end
            S_STRIDE_X: begin
                n_stride[0] = mul_p[VLW_STRIDE_W-1:0];
                n_state     = S_STRIDE_Y;
            end
            S_STRIDE_Y: begin
                n_stride[1] = mul_p[VLW_STRIDE_W-1:0];
                n_state     = S_STRIDE_Z;
            end
            S_STRIDE_Z: begin
                n_stride[2] = mul_p[VLW_STRIDE_W-1:0];
                n_state     = S_PLANE;
            end
            S_PLANE: begin
                n_plane = mul_p[VLW_PLANE_W-1:0];
                n_state = S_ROW;
            end
            S_ROW: begin
                n_idx   = VLW_INDEX_W'(r_pos[2'(AXIS_X)]) + mul_p[VLW_INDEX_W-1:0];
                n_state = S_DEPTH;
            end
            S_DEPTH: begin
                n_idx   = r_idx + mul_p[VLW_INDEX_W-1:0];
                n_state = S_WALK;
            end
            S_WALK: begin
                // advance one axis, emit the voxel reached
                n_pos = step_pos;
                if (r_zero[ax]) begin
                    n_late[ax] = 1'b1;
                end else begin
                    n_t[ax] = r_t[ax] + VLW_TIME_W'(r_stride[ax]);
                end
                n_idx      = r_neg[ax] ? r_idx - idx_inc : r_idx + idx_inc;
                n_cnt      = cnt_inc;
                n_strobe   = 1'b1;
                n_out_x    = step_pos[0];
                n_out_y    = step_pos[1];
                n_out_z    = step_pos[2];
                n_out_idx  = r_neg[ax] ? r_idx - idx_inc : r_idx + idx_inc;
                n_out_last = arrive;
                if (arrive || (cnt_inc == VLW_CNT_W'(VLW_WALK_LIMIT))) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // ------------------------------------------------------------------------
    // State and registered outputs
    // ------------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_strobe <= 1'b0;
            r_late   <= '0;
            r_size_x <= RST_SIZE;
            r_size_y <= RST_SIZE;
            r_size_z <= RST_SIZE;
        end else begin
            r_state  <= n_state;
            r_strobe <= n_strobe;
            r_late   <= n_late;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_GRID_X: r_size_x <= i_cfg_data;
                    CFG_GRID_Y: r_size_y <= i_cfg_data;
                    CFG_GRID_Z: r_size_z <= i_cfg_data;
                    default: ;  // drop writes beyond the register list
                endcase
            end
        end
        r_pos      <= n_pos;
        r_fin      <= n_fin;
        r_mag      <= n_mag;
        r_neg      <= n_neg;
        r_zero     <= n_zero;
        r_t        <= n_t;
        r_stride   <= n_stride;
        r_plane    <= n_plane;
        r_idx      <= n_idx;
        r_cnt      <= n_cnt;
        r_out_x    <= n_out_x;
        r_out_y    <= n_out_y;
        r_out_z    <= n_out_z;
        r_out_idx  <= n_out_idx;
        r_out_last <= n_out_last;
    end

    assign busy            = (r_state != S_IDLE);
    assign o_result_strobe = r_strobe;
    assign o_voxel_x       = r_out_x;
    assign o_voxel_y       = r_out_y;
    assign o_voxel_z       = r_out_z;
    assign o_voxel_index   = r_out_idx;
    assign o_last_step     = r_out_last;

    // ------------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------------
    // A zero-length segment leaves the block idle.
    a_empty_segment: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && same_voxel) |=> !busy)
        else $error("zero-length segment started a walk");

    // Only the final voxel may be emitted as the walk ends.
    a_mid_walk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_strobe && !o_last_step) |-> (r_state == S_WALK))
        else $error("walk ended before reaching the end voxel");

    // Nothing follows the end voxel of a segment.
    a_last_alone: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_strobe && o_last_step) |=> !o_result_strobe)
        else $error("result emitted after the end voxel");

    // Only an axis without delta can be retired.
    a_late_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WALK) |-> ((r_late & ~r_zero) == 3'b000))
        else $error("moving axis retired");

endmodule
